// ===== design/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the pixel replicating upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'd1;

    // register widths and limits
    localparam int SCALE_W = 7;
    localparam int WIDTH_W = 11;
    localparam int PAD_W   = 2;
    localparam logic [SCALE_W-1:0] SCALE_LIMIT = 7'd100;
    localparam logic [7:0] PAD_BYTE = 8'h00;
    localparam int ROW_ALIGN = 4;

    // default line buffer depth
    localparam int MAX_WIDTH_DEF = 1024;

    // pixel word
    localparam int PIX_W = 24;

    // request and item kind codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_PULL   = 1'b1;
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_PAD   = 1'b1;

    // input request payload
    typedef struct packed {
        logic       req_type;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_in_req;

    // result payload
    typedef struct packed {
        logic       accepted;
        logic       out_valid;
        logic       out_kind;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       row_end;
        logic       group_end;
    } t_out_rsp;

    // control fields of one result, colors come later from the buffer
    typedef struct packed {
        logic accepted;
        logic out_valid;
        logic out_kind;
        logic row_end;
        logic group_end;
        logic use_ram;
    } t_meta;

endpackage

// ===== design/pru_ram.sv =====
// ----------------------------------------------------------------------------
// pru_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pru_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [DATA_W-1:0]                        i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [DATA_W-1:0]                        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pru_ctrl.sv =====
// ----------------------------------------------------------------------------
// pru_ctrl
// Configuration registers, fill and readout counters, line buffer access.
// ----------------------------------------------------------------------------
module pru_ctrl
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]                         i_cfg_data,
    input  logic                                          i_acc,
    input  logic                                          i_req_type,
    output t_meta                                         o_meta,
    output logic                                          o_we,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_waddr,
    output logic                                          o_re,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_raddr
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW = (AW > WIDTH_W) ? AW : WIDTH_W;

    logic [SCALE_W-1:0] r_scale;
    logic [WIDTH_W-1:0] r_width;

    logic [WIDTH_W-1:0] r_fill_count, n_fill_count;
    logic               r_line_ready, n_line_ready;
    logic [WIDTH_W-1:0] r_read_index, n_read_index;
    logic [SCALE_W-1:0] r_col_rep, n_col_rep;
    logic [SCALE_W-1:0] r_row_rep, n_row_rep;
    logic [PAD_W-1:0]   r_pad_sent, n_pad_sent;
    logic               r_in_pad, n_in_pad;

    logic [SCALE_W-1:0] eff_scale;
    logic [WIDTH_W-1:0] eff_width;
    logic [PAD_W-1:0]   pad;
    logic [3:0]         pad_prod;
    logic [WIDTH_W:0]   fill_nx;
    logic [WIDTH_W:0]   rd_nx;
    logic [SCALE_W:0]   col_nx;
    logic [SCALE_W:0]   row_nx;
    logic [PAD_W:0]     pad_nx;
    logic               row_done;
    logic [XW-1:0]      waddr_x;
    logic [XW-1:0]      raddr_x;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_width <= WIDTH_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_WIDTH: r_width <= i_cfg_data[WIDTH_W-1:0];
                default:   r_scale <= r_scale;
            endcase
        end
    end

    // clamp registers into their working range
    always_comb begin
        if (r_scale == '0) begin
            eff_scale = SCALE_W'(1);
        end else if (r_scale > SCALE_LIMIT) begin
            eff_scale = SCALE_LIMIT;
        end else begin
            eff_scale = r_scale;
        end
        if (r_width == '0) begin
            eff_width = WIDTH_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_width = WIDTH_W'(MAX_WIDTH);
        end else begin
            eff_width = r_width;
        end
    end

    // row padding, only the low two bits of the product matter
    assign pad_prod = eff_scale[1:0] * eff_width[1:0];
    assign pad      = pad_prod[PAD_W-1:0];

    assign fill_nx = {1'b0, r_fill_count} + 1'b1;
    assign rd_nx   = {1'b0, r_read_index} + 1'b1;
    assign col_nx  = {1'b0, r_col_rep} + 1'b1;
    assign row_nx  = {1'b0, r_row_rep} + 1'b1;
    assign pad_nx  = {1'b0, r_pad_sent} + 1'b1;

    // next state for one accepted request
    always_comb begin
        n_fill_count = r_fill_count;
        n_line_ready = r_line_ready;
        n_read_index = r_read_index;
        n_col_rep    = r_col_rep;
        n_row_rep    = r_row_rep;
        n_pad_sent   = r_pad_sent;
        n_in_pad     = r_in_pad;
        o_meta       = '0;
        o_we         = 1'b0;
        o_re         = 1'b0;
        row_done     = 1'b0;

        if (i_acc) begin
            if (i_req_type == REQ_WRITE) begin
                if (!r_line_ready) begin
                    if (r_fill_count >= eff_width) begin
                        // width lowered during fill: drop pixel, start output
                        n_line_ready = 1'b1;
                        n_read_index = '0;
                        n_col_rep    = '0;
                        n_row_rep    = '0;
                        n_pad_sent   = '0;
                        n_in_pad     = 1'b0;
                    end else begin
                        o_we            = 1'b1;
                        o_meta.accepted = 1'b1;
                        n_fill_count    = fill_nx[WIDTH_W-1:0];
                        if (fill_nx >= {1'b0, eff_width}) begin
                            n_line_ready = 1'b1;
                            n_read_index = '0;
                            n_col_rep    = '0;
                            n_row_rep    = '0;
                            n_pad_sent   = '0;
                            n_in_pad     = 1'b0;
                        end
                    end
                end
            end else if (r_line_ready) begin
                o_meta.out_valid = 1'b1;
                if (!r_in_pad) begin
                    // pixel phase: read the buffer, step column counters
                    o_re           = 1'b1;
                    o_meta.use_ram = 1'b1;
                    o_meta.out_kind = KIND_PIXEL;
                    if (col_nx >= {1'b0, eff_scale}) begin
                        n_col_rep = '0;
                        if (rd_nx >= {1'b0, eff_width}) begin
                            n_read_index = '0;
                            if (pad != '0) begin
                                n_in_pad = 1'b1;
                            end else begin
                                row_done = 1'b1;
                            end
                        end else begin
                            n_read_index = rd_nx[WIDTH_W-1:0];
                        end
                    end else begin
                        n_col_rep = col_nx[SCALE_W-1:0];
                    end
                end else begin
                    // padding phase
                    o_meta.out_kind = KIND_PAD;
                    if (pad_nx >= {1'b0, pad}) begin
                        n_pad_sent = '0;
                        n_in_pad   = 1'b0;
                        row_done   = 1'b1;
                    end else begin
                        n_pad_sent = pad_nx[PAD_W-1:0];
                    end
                end

                // end of row, and end of the repeated row group
                if (row_done) begin
                    o_meta.row_end = 1'b1;
                    if (row_nx >= {1'b0, eff_scale}) begin
                        o_meta.group_end = 1'b1;
                        n_row_rep    = '0;
                        n_line_ready = 1'b0;
                        n_fill_count = '0;
                        n_read_index = '0;
                        n_col_rep    = '0;
                        n_pad_sent   = '0;
                        n_in_pad     = 1'b0;
                    end else begin
                        n_row_rep = row_nx[SCALE_W-1:0];
                    end
                end
            end
        end
    end

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_count <= '0;
            r_line_ready <= 1'b0;
            r_read_index <= '0;
            r_col_rep    <= '0;
            r_row_rep    <= '0;
            r_pad_sent   <= '0;
            r_in_pad     <= 1'b0;
        end else begin
            r_fill_count <= n_fill_count;
            r_line_ready <= n_line_ready;
            r_read_index <= n_read_index;
            r_col_rep    <= n_col_rep;
            r_row_rep    <= n_row_rep;
            r_pad_sent   <= n_pad_sent;
            r_in_pad     <= n_in_pad;
        end
    end

    // buffer addresses, counters stay below the buffer depth when used
    assign waddr_x = XW'(r_fill_count);
    assign raddr_x = XW'(r_read_index);
    assign o_waddr = waddr_x[AW-1:0];
    assign o_raddr = raddr_x[AW-1:0];

endmodule

// ===== design/pru_out.sv =====
// ----------------------------------------------------------------------------
// pru_out
// Two result stages: buffer read stage and output register with handshake.
// ----------------------------------------------------------------------------
module pru_out
    import pru_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  t_meta            i_meta,
    input  logic [PIX_W-1:0] i_rdata,
    output logic             o_busy,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_rsp         o_rsp
);

    logic     r_s1_valid;
    t_meta    r_s1_meta;
    logic     r_out_valid;
    t_out_rsp r_out;
    logic     s1_adv;
    t_out_rsp n_out;

    // stage one moves on when the output register is free or being taken
    assign s1_adv = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_busy = r_s1_valid && !s1_adv;

    // assemble the result from control fields and buffer data
    always_comb begin
        n_out           = '0;
        n_out.accepted  = r_s1_meta.accepted;
        n_out.out_valid = r_s1_meta.out_valid;
        n_out.out_kind  = r_s1_meta.out_kind;
        n_out.row_end   = r_s1_meta.row_end;
        n_out.group_end = r_s1_meta.group_end;
        if (r_s1_meta.use_ram) begin
            n_out.out_blue  = i_rdata[7:0];
            n_out.out_green = i_rdata[15:8];
            n_out.out_red   = i_rdata[23:16];
        end else begin
            n_out.out_blue  = PAD_BYTE;
            n_out.out_green = PAD_BYTE;
            n_out.out_red   = PAD_BYTE;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_acc || (r_s1_valid && !s1_adv);
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_meta <= i_meta;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

// ===== design/pixel_replicate_upscaler.sv =====
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler
// Nearest neighbor integer upscaler: fills a line buffer with pixel writes,
// then streams each pixel scale times per row, row padding, scale rows.
// ----------------------------------------------------------------------------
// path: an accepted request passes the buffer read stage, then the output register
// throughput: one request per cycle while o_stall is low, set by the single buffer read per pull
// reset: synchronous, active low; scale and line width return to 1, line empty
// line buffer contents are not cleared by reset and need no clearing pass
module pixel_replicate_upscaler
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_req               i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_rsp              o_rsp
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic             acc;
    logic             busy;
    t_meta            meta;
    logic             we;
    logic             re;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [PIX_W-1:0] rdata;

    // request acceptance
    assign o_stall = busy;
    assign acc     = i_valid && !busy;

    // counters and buffer control
    pru_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_req_type (i_req.req_type),
        .o_meta     (meta),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_re       (re),
        .o_raddr    (raddr)
    );

    // line buffer
    pru_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({i_req.in_red, i_req.in_green, i_req.in_blue}),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result stages
    pru_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_meta  (meta),
        .i_rdata (rdata),
        .o_busy  (busy),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

endmodule
